>>> rtl/dsched_pkg.sv
// dsched_pkg: shared constants for the disk request scheduler
// holds default sizes, policy codes, result status codes and input action codes
// no dependencies
package dsched_pkg;

  localparam int DSCHED_DEPTH    = 32;
  localparam int DSCHED_TRACK_W  = 16;
  localparam int DSCHED_ID_W     = 16;
  localparam int DSCHED_POLICY_W = 3;
  localparam int DSCHED_STATUS_W = 2;

  // scheduling policy codes
  localparam logic [DSCHED_POLICY_W-1:0] POL_FIFO  = 3'd0;
  localparam logic [DSCHED_POLICY_W-1:0] POL_SSTF  = 3'd1;
  localparam logic [DSCHED_POLICY_W-1:0] POL_LOOK  = 3'd2;
  localparam logic [DSCHED_POLICY_W-1:0] POL_CLOOK = 3'd3;
  localparam logic [DSCHED_POLICY_W-1:0] POL_FLOOK = 3'd4;

  // result status codes
  localparam logic [DSCHED_STATUS_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [DSCHED_STATUS_W-1:0] ST_GRANTED = 2'd1;
  localparam logic [DSCHED_STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [DSCHED_STATUS_W-1:0] ST_FULL    = 2'd3;

  // input action codes
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_GET = 1'b1;

endpackage

>>> rtl/dsched_req_if.sv
// dsched_req_if: request channel (valid/ready plus request payload)
// depends on dsched_pkg for default widths
interface dsched_req_if
  import dsched_pkg::*;
#(
  parameter int TRACK_WIDTH = DSCHED_TRACK_W,
  parameter int ID_WIDTH    = DSCHED_ID_W
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [ID_WIDTH-1:0]    request_id;
  logic [TRACK_WIDTH-1:0] track;
  logic [TRACK_WIDTH-1:0] head_track;

  modport source (output valid, action, request_id, track, head_track, input ready);
  modport sink   (input valid, action, request_id, track, head_track, output ready);
endinterface

>>> rtl/dsched_rsp_if.sv
// dsched_rsp_if: result channel (valid/ready plus result payload)
// depends on dsched_pkg for default widths
interface dsched_rsp_if
  import dsched_pkg::*;
#(
  parameter int TRACK_WIDTH = DSCHED_TRACK_W,
  parameter int ID_WIDTH    = DSCHED_ID_W
);
  logic                       valid;
  logic                       ready;
  logic [DSCHED_STATUS_W-1:0] status;
  logic [ID_WIDTH-1:0]        granted_id;
  logic [TRACK_WIDTH-1:0]     granted_track;
  logic                       moving_down;

  modport source (output valid, status, granted_id, granted_track, moving_down, input ready);
  modport sink   (input valid, status, granted_id, granted_track, moving_down, output ready);
endinterface

>>> rtl/disk_request_scheduler.sv
// disk_request_scheduler: top level of the disk request scheduler
// chain of dsched_cell slots plus control; uses dsched_pkg and the
// dsched_req_if / dsched_rsp_if channel interfaces
//
// Usage:
//   in_if  : request transfers (action add or get, id, track, head position)
//   out_if : one result transfer per request (status, granted id and track,
//            sweep direction after the request)
//   cfg_we / cfg_wdata : policy register, written whenever cfg_we is high
// Requests are handled one at a time. An add goes from the idle state straight to
// the done state. A get passes through the scan state while the search token walks
// the cell chain one cell per cycle, oldest slot first, and the grant and compaction
// of the younger slots happen on the commit in the done state. A get on an empty
// queue also walks the whole chain.
// The result sits in an output register; a new request is taken while it
// waits, and a finished request waits in its last state until the result
// register is free. When the receiver stalls, the block holds at most one
// result plus one request in work.
// Reset empties the queue, sets the sweep upward and selects FIFO.
module disk_request_scheduler
  import dsched_pkg::*;
#(
  parameter int QUEUE_DEPTH = DSCHED_DEPTH,
  parameter int TRACK_WIDTH = DSCHED_TRACK_W,
  parameter int ID_WIDTH    = DSCHED_ID_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dsched_req_if.sink                 in_if,
  dsched_rsp_if.source               out_if,
  input  logic                       cfg_we,
  input  logic [DSCHED_POLICY_W-1:0] cfg_wdata
);

  localparam int IXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                   found;
    logic [IXW-1:0]         idx;
    logic [TRACK_WIDTH-1:0] key;
  } best_t;

  typedef struct packed {
    logic  any_act;
    best_t up_all;
    best_t dn_all;
    best_t up_act;
    best_t dn_act;
    best_t near;
    best_t low;
  } tok_t;

  typedef struct packed {
    logic                   valid;
    logic                   pend;
    logic [TRACK_WIDTH-1:0] track;
    logic [ID_WIDTH-1:0]    id;
  } ent_t;

  typedef struct packed {
    logic                   add;
    logic                   grant;
    logic                   clr;
    logic [IXW-1:0]         idx;
    logic [TRACK_WIDTH-1:0] trk;
    logic [ID_WIDTH-1:0]    id;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [DSCHED_POLICY_W-1:0] policy_r;
  logic                       act_r;
  logic [ID_WIDTH-1:0]        rid_r;
  logic [TRACK_WIDTH-1:0]     trk_r;
  logic [TRACK_WIDTH-1:0]     head_r;
  logic [CW-1:0]              count_r;
  logic [IXW-1:0]             scan_cnt_r;
  logic                       dir_r;
  logic                       out_valid_r;
  logic [DSCHED_STATUS_W-1:0] out_status_r;
  logic [ID_WIDTH-1:0]        out_gid_r;
  logic [TRACK_WIDTH-1:0]     out_gtrk_r;
  logic                       out_down_r;

  tok_t  tok_w [QUEUE_DEPTH];
  ent_t  ent_w [QUEUE_DEPTH];
  tok_t  tok_first;
  ent_t  ent_none;
  cmd_t  cmd;
  tok_t  tf;
  best_t up_b, dn_b, ahead_b, back_b;
  ent_t  sel_e;

  logic                       in_xfer;
  logic                       commit;
  logic                       full;
  logic                       grant;
  logic                       clr;
  logic [IXW-1:0]             sel_idx;
  logic [DSCHED_STATUS_W-1:0] status;
  logic                       dir_look;
  logic                       dir_nxt;
  logic                       pick_low;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid & in_if.ready;
  assign commit      = (state_r == S_DONE) & (~out_valid_r | out_if.ready);
  assign full        = (count_r == CW'(QUEUE_DEPTH));

  // chain of slots; the token enters empty at the oldest slot
  assign tok_first = '0;
  assign ent_none  = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dsched_cell #(
      .IDX    (i),
      .TW     (TRACK_WIDTH),
      .IW     (ID_WIDTH),
      .IXW    (IXW),
      .BEST_T (best_t),
      .TOK_T  (tok_t),
      .ENT_T  (ent_t),
      .CMD_T  (cmd_t)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .head    (head_r),
      .tok_in  ((i == 0) ? tok_first : tok_w[(i == 0) ? 0 : i - 1]),
      .tok_out (tok_w[i]),
      .nb_in   ((i == QUEUE_DEPTH - 1) ? ent_none : ent_w[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .ent_out (ent_w[i]),
      .cmd     (cmd)
    );
  end

  assign tf = tok_w[QUEUE_DEPTH-1];

  // candidate sets for the sweep policies (flook uses active batch if any)
  always_comb begin
    if (policy_r == POL_FLOOK && tf.any_act) begin
      up_b = tf.up_act;
      dn_b = tf.dn_act;
    end else begin
      up_b = tf.up_all;
      dn_b = tf.dn_all;
    end
    ahead_b  = dir_r ? dn_b : up_b;
    back_b   = dir_r ? up_b : dn_b;
    dir_look = ahead_b.found ? dir_r : ~dir_r;
    pick_low = ~tf.up_all.found;
  end

  // pick the slot to grant
  always_comb begin
    sel_idx = '0;
    grant   = 1'b0;
    clr     = 1'b0;
    status  = ST_EMPTY;
    if (act_r == ACT_ADD) begin
      status = full ? ST_FULL : ST_ADDED;
    end else if (count_r != '0) begin
      grant  = 1'b1;
      status = ST_GRANTED;
      case (policy_r)
        POL_SSTF: begin
          sel_idx = tf.near.idx;
        end
        POL_LOOK: begin
          sel_idx = ahead_b.found ? ahead_b.idx : back_b.idx;
        end
        POL_CLOOK: begin
          sel_idx = pick_low ? tf.low.idx : tf.up_all.idx;
        end
        POL_FLOOK: begin
          sel_idx = ahead_b.found ? ahead_b.idx : back_b.idx;
          clr     = ~tf.any_act;
        end
        default: begin
          sel_idx = '0;
        end
      endcase
    end
  end

  assign sel_e = ent_w[sel_idx];

  // sweep direction after this request
  always_comb begin
    dir_nxt = dir_r;
    if (grant) begin
      case (policy_r)
        POL_SSTF:  dir_nxt = sel_e.track < head_r;
        POL_LOOK:  dir_nxt = dir_look;
        POL_CLOOK: dir_nxt = pick_low;
        POL_FLOOK: dir_nxt = dir_look;
        default:   dir_nxt = ~(ent_w[0].track > head_r);
      endcase
    end
  end

  // slot command; add and grant fire only in the commit cycle
  always_comb begin
    cmd       = '0;
    cmd.add   = commit & (act_r == ACT_ADD) & ~full;
    cmd.grant = commit & grant;
    cmd.clr   = clr;
    cmd.idx   = (act_r == ACT_ADD) ? count_r[IXW-1:0] : sel_idx;
    cmd.trk   = trk_r;
    cmd.id    = rid_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_if.action == ACT_GET) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == IXW'(QUEUE_DEPTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_cnt_r <= '0;
      count_r    <= '0;
      dir_r      <= 1'b0;
      policy_r   <= POL_FIFO;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SCAN) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end else begin
        scan_cnt_r <= '0;
      end
      if (cmd.add) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.grant) begin
        count_r <= count_r - 1'b1;
      end
      if (commit) begin
        dir_r <= dir_nxt;
      end
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r  <= in_if.action;
      rid_r  <= in_if.request_id;
      trk_r  <= in_if.track;
      head_r <= in_if.head_track;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= status;
      out_gid_r    <= grant ? sel_e.id : '0;
      out_gtrk_r   <= grant ? sel_e.track : '0;
      out_down_r   <= dir_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.granted_id    = out_gid_r;
  assign out_if.granted_track = out_gtrk_r;
  assign out_if.moving_down   = out_down_r;

  // queue fill never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a grant removes exactly one entry
  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |=> count_r == $past(count_r) - 1'b1)
    else $error("grant did not shrink queue");

  // a new result appears only after a commit in the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result without commit");

  // the oldest slot is valid whenever the queue holds anything
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> ent_w[0].valid)
    else $error("queue entries not a prefix");

endmodule

>>> rtl/dsched_cell.sv
// dsched_cell: one queue slot of the scheduler chain
// holds one request, folds it into the search token passed from the older
// neighbor and shifts from the younger neighbor on removal; uses dsched_pkg
module dsched_cell
  import dsched_pkg::*;
#(
  parameter int  IDX    = 0,
  parameter int  TW     = DSCHED_TRACK_W,
  parameter int  IW     = DSCHED_ID_W,
  parameter int  IXW    = 5,
  parameter type BEST_T = logic,
  parameter type TOK_T  = logic,
  parameter type ENT_T  = logic,
  parameter type CMD_T  = logic
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [TW-1:0] head,
  input  TOK_T          tok_in,
  output TOK_T          tok_out,
  input  ENT_T          nb_in,
  output ENT_T          ent_out,
  input  CMD_T          cmd
);

  logic          valid_r;
  logic          pend_r;
  logic [TW-1:0] track_r;
  logic [IW-1:0] id_r;
  TOK_T          tok_r;
  TOK_T          tok_nxt;
  logic [TW-1:0] span;
  logic          is_up;
  logic          is_dn;
  logic          at_or_after;

  // replace a best record when strictly closer (older entry wins ties)
  function automatic BEST_T upd(input BEST_T b, input logic cond, input logic [TW-1:0] key);
    BEST_T r;
    r = b;
    if (cond && (!b.found || key < b.key)) begin
      r.found = 1'b1;
      r.idx   = IXW'(IDX);
      r.key   = key;
    end
    return r;
  endfunction

  // local distance and direction of this entry against the head
  assign is_up       = track_r >= head;
  assign is_dn       = track_r <= head;
  assign span        = is_up ? (track_r - head) : (head - track_r);
  assign at_or_after = IXW'(IDX) >= cmd.idx;

  // fold this entry into the search token
  always_comb begin
    tok_nxt = tok_in;
    if (valid_r) begin
      tok_nxt.any_act = tok_in.any_act | ~pend_r;
      tok_nxt.up_all  = upd(tok_in.up_all, is_up, span);
      tok_nxt.dn_all  = upd(tok_in.dn_all, is_dn, span);
      tok_nxt.up_act  = upd(tok_in.up_act, is_up & ~pend_r, span);
      tok_nxt.dn_act  = upd(tok_in.dn_act, is_dn & ~pend_r, span);
      tok_nxt.near    = upd(tok_in.near, 1'b1, span);
      tok_nxt.low     = upd(tok_in.low, 1'b1, track_r);
    end
  end

  // token register toward the younger neighbor
  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;

  // slot control: load on add, shift from neighbor on grant, clear pending on a batch clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (cmd.add && cmd.idx == IXW'(IDX)) begin
      valid_r <= 1'b1;
      pend_r  <= 1'b1;
    end else if (cmd.grant && at_or_after) begin
      valid_r <= nb_in.valid;
      pend_r  <= nb_in.pend & ~cmd.clr;
    end else if (cmd.grant && cmd.clr) begin
      pend_r  <= 1'b0;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (cmd.add && cmd.idx == IXW'(IDX)) begin
      track_r <= cmd.trk;
      id_r    <= cmd.id;
    end else if (cmd.grant && at_or_after) begin
      track_r <= nb_in.track;
      id_r    <= nb_in.id;
    end
  end

  always_comb begin
    ent_out       = '0;
    ent_out.valid = valid_r;
    ent_out.pend  = pend_r;
    ent_out.track = track_r;
    ent_out.id    = id_r;
  end

endmodule
